// ----- rtl/gsct_pkg.sv -----
`timescale 1ns / 1ps
package gsct_pkg;

  // Event kinds
  localparam logic [2:0] KIND_BEGIN   = 3'd0;
  localparam logic [2:0] KIND_QUEUE   = 3'd1;
  localparam logic [2:0] KIND_SCOPE   = 3'd2;
  localparam logic [2:0] KIND_EXPIRE  = 3'd3;
  localparam logic [2:0] KIND_OBSERVE = 3'd4;

  // Queue result codes
  localparam logic [1:0] Q_PENDING   = 2'd0;
  localparam logic [1:0] Q_SUCCESS   = 2'd1;
  localparam logic [1:0] Q_ERROR     = 2'd2;
  localparam logic [1:0] Q_CANCELLED = 2'd3;

  // Scope result codes
  localparam logic [1:0] S_PENDING = 2'd0;
  localparam logic [1:0] S_CLEAN   = 2'd1;
  localparam logic [1:0] S_ERROR   = 2'd2;

  // Observe verdicts
  localparam logic [1:0] VERDICT_NONE    = 2'd0;
  localparam logic [1:0] VERDICT_SUCCESS = 2'd1;
  localparam logic [1:0] VERDICT_FAILURE = 2'd2;

  localparam int unsigned TagW    = 64;
  localparam int unsigned EpochW  = 64;
  localparam int unsigned RejectW = 32;

  typedef struct packed {
    logic [2:0]        kind;
    logic [TagW-1:0]   tag;
    logic [EpochW-1:0] error_epoch;
    logic [1:0]        outcome;
    logic              dev_lost;
    logic              drained;
  } evt_t;

  typedef struct packed {
    logic               accepted;
    logic [1:0]         terminal;
    logic               busy_res;
    logic [RejectW-1:0] reject_total;
  } res_t;

endpackage

// ----- rtl/gsct_evt_if.sv -----
`timescale 1ns / 1ps
interface gsct_evt_if
  import gsct_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [2:0]        kind;
  logic [TagW-1:0]   tag;
  logic [EpochW-1:0] error_epoch;
  logic [1:0]        outcome;
  logic              dev_lost;
  logic              drained;

  modport source (
    output valid, kind, tag, error_epoch, outcome, dev_lost, drained,
    input  ready
  );
  modport sink (
    input  valid, kind, tag, error_epoch, outcome, dev_lost, drained,
    output ready
  );
endinterface

// ----- rtl/gsct_res_if.sv -----
`timescale 1ns / 1ps
interface gsct_res_if
  import gsct_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               accepted;
  logic [1:0]         terminal;
  logic               busy_res;
  logic [RejectW-1:0] reject_total;

  modport source (
    output valid, accepted, terminal, busy_res, reject_total,
    input  ready
  );
  modport sink (
    input  valid, accepted, terminal, busy_res, reject_total,
    output ready
  );
endinterface

// ----- rtl/gsct_stage.sv -----
`timescale 1ns / 1ps
module gsct_stage
  import gsct_pkg::*;
#(
  parameter type T = evt_t
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q, valid_d;
  T     data_q;

  // Take a new transfer when empty or when the held one leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/gsct_core.sv -----
`timescale 1ns / 1ps
module gsct_core
  import gsct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic fire_i,
  input  evt_t evt_i,
  output res_t res_o
);

  logic               active_q, active_d;
  logic [TagW-1:0]    tag_q, tag_d;
  logic [EpochW-1:0]  base_q, base_d;
  logic [1:0]         queue_q, queue_d;
  logic [1:0]         scope_q, scope_d;
  logic               expired_q, expired_d;
  logic [RejectW-1:0] reject_q, reject_d;

  logic       tag_hit;
  logic       poisoned;
  logic       reject;
  logic       accepted;
  logic [1:0] verdict;

  assign tag_hit  = active_q && (evt_i.tag == tag_q);
  assign poisoned = (queue_q == Q_ERROR) || (queue_q == Q_CANCELLED) ||
                    (scope_q == S_ERROR) || evt_i.dev_lost ||
                    (evt_i.error_epoch != base_q);

  always_comb begin
    active_d  = active_q;
    tag_d     = tag_q;
    base_d    = base_q;
    queue_d   = queue_q;
    scope_d   = scope_q;
    expired_d = expired_q;
    reject    = 1'b0;
    accepted  = 1'b0;
    verdict   = VERDICT_NONE;
    case (evt_i.kind)
      KIND_BEGIN: begin
        if (!active_q && (evt_i.tag != '0)) begin
          tag_d     = evt_i.tag;
          base_d    = evt_i.error_epoch;
          queue_d   = Q_PENDING;
          scope_d   = S_PENDING;
          expired_d = 1'b0;
          active_d  = 1'b1;
          accepted  = 1'b1;
        end
      end
      KIND_QUEUE: begin
        if (tag_hit && (evt_i.outcome != Q_PENDING) && (queue_q == Q_PENDING)) begin
          queue_d  = evt_i.outcome;
          accepted = 1'b1;
        end else begin
          reject = 1'b1;
        end
      end
      KIND_SCOPE: begin
        if (tag_hit && ((evt_i.outcome == S_CLEAN) || (evt_i.outcome == S_ERROR)) &&
            (scope_q == S_PENDING)) begin
          scope_d  = evt_i.outcome;
          accepted = 1'b1;
        end else begin
          reject = 1'b1;
        end
      end
      KIND_EXPIRE: begin
        if (tag_hit && !expired_q) begin
          expired_d = 1'b1;
          accepted  = 1'b1;
        end else begin
          reject = 1'b1;
        end
      end
      KIND_OBSERVE: begin
        if (tag_hit) begin
          accepted = 1'b1;
          if (poisoned) begin
            if (evt_i.drained) begin
              verdict = VERDICT_FAILURE;
            end
          end else if ((queue_q == Q_SUCCESS) && (scope_q == S_CLEAN)) begin
            verdict = VERDICT_SUCCESS;
          end else if (evt_i.drained) begin
            verdict = VERDICT_FAILURE;
          end
          if (verdict != VERDICT_NONE) begin
            active_d = 1'b0;
          end
        end else begin
          reject = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // Saturate the reject count at all ones.
    reject_d = reject_q;
    if (reject && (reject_q != '1)) begin
      reject_d = reject_q + RejectW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      tag_q     <= '0;
      base_q    <= '0;
      queue_q   <= Q_PENDING;
      scope_q   <= S_PENDING;
      expired_q <= 1'b0;
      reject_q  <= '0;
    end else if (fire_i) begin
      active_q  <= active_d;
      tag_q     <= tag_d;
      base_q    <= base_d;
      queue_q   <= queue_d;
      scope_q   <= scope_d;
      expired_q <= expired_d;
      reject_q  <= reject_d;
    end
  end

  assign res_o.accepted     = accepted;
  assign res_o.terminal     = verdict;
  assign res_o.busy_res     = active_d;
  assign res_o.reject_total = reject_d;

`ifndef ASSERT_OFF
  a_verdict_deactivates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (verdict != VERDICT_NONE) |=> !active_q)
    else $error("tracker still active after a verdict");

  a_success_needs_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (verdict == VERDICT_SUCCESS) |-> (queue_q == Q_SUCCESS) && (scope_q == S_CLEAN))
    else $error("success verdict without clean results");

  a_idle_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(active_q) && $stable(reject_q) && $stable(tag_q))
    else $error("state moved without a transfer");

  a_reject_steps_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && reject && ($past(reject_q) == reject_q) |=> (reject_q == $past(reject_q) + RejectW'(1))
      || (reject_q == '1))
    else $error("reject count did not advance");

  a_begin_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (evt_i.kind == KIND_BEGIN) && accepted |=> active_q && (queue_q == Q_PENDING))
    else $error("accepted begin did not arm the tracker");
`endif

endmodule

// ----- rtl/gpu_submission_completion_tracker.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Modport         Payload
// evt_i     in   gsct_evt_if     kind, tag, error_epoch, outcome, dev_lost, drained
// res_o     out  gsct_res_if     accepted, terminal, busy_res, reject_total
//
// One event per clock sustained while the result side does not stall; each event gives
// exactly one result, which passes through the event register, then the result register.
// The tracker state updates in the cycle an event moves from the event register
// into the result register, so back-to-back events see each other's effect.
// rst_ni clears the tracker (inactive, results pending, reject count zero) and
// empties both registers.
// A stalled result holds in the result register; evt_i.ready stays high while
// the event register is empty or can advance.
module gpu_submission_completion_tracker
  import gsct_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gsct_evt_if.sink  evt_i,
  gsct_res_if.source res_o
);

  evt_t evt_in;
  evt_t evt_q;
  logic evt_valid;
  logic core_fire;
  logic res_ready;
  res_t res_d;
  res_t res_q;

  // Gather the incoming payload into one struct.
  assign evt_in.kind        = evt_i.kind;
  assign evt_in.tag         = evt_i.tag;
  assign evt_in.error_epoch = evt_i.error_epoch;
  assign evt_in.outcome     = evt_i.outcome;
  assign evt_in.dev_lost    = evt_i.dev_lost;
  assign evt_in.drained     = evt_i.drained;

  // Event register: holds one transfer ahead of the tracker logic.
  gsct_stage #(
    .T (evt_t)
  ) u_evt_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (evt_i.valid),
    .ready_o (evt_i.ready),
    .data_i  (evt_in),
    .valid_o (evt_valid),
    .ready_i (res_ready),
    .data_o  (evt_q)
  );

  // Apply the event only when its result has a place to go.
  assign core_fire = evt_valid && res_ready;

  gsct_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (core_fire),
    .evt_i  (evt_q),
    .res_o  (res_d)
  );

  // Result register: decouples the consumer from the tracker logic.
  gsct_stage #(
    .T (res_t)
  ) u_res_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (evt_valid),
    .ready_o (res_ready),
    .data_i  (res_d),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res_q)
  );

  assign res_o.accepted     = res_q.accepted;
  assign res_o.terminal     = res_q.terminal;
  assign res_o.busy_res     = res_q.busy_res;
  assign res_o.reject_total = res_q.reject_total;

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import gsct_pkg::*;

  // Kinds the tracker must ignore, and the one outcome code scope has no use for
  localparam logic [2:0] KIND_RSVD5  = 3'd5;
  localparam logic [2:0] KIND_RSVD6  = 3'd6;
  localparam logic [2:0] KIND_RSVD7  = 3'd7;
  localparam logic [1:0] S_UNDEFINED = 2'd3;

  localparam logic [63:0] TAG_MAX   = '1;
  localparam logic [63:0] EPOCH_MAX = '1;

  localparam int unsigned DrainLimit = 2000;

  logic clk_i;
  logic rst_ni;

  gsct_evt_if evt_if ();
  gsct_res_if res_if ();

  gpu_submission_completion_tracker u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt_if),
    .res_o  (res_if)
  );

  // Tracker copy kept in step with every transferred event
  logic        trk_active;
  logic [63:0] trk_tag;
  logic [63:0] trk_baseline;
  logic [1:0]  trk_queue;
  logic [1:0]  trk_scope;
  logic        trk_expired;
  logic [31:0] trk_rejects;

  res_t due_results[$];
  int   fail_count;
  int   items_sent;
  bit   calm;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #100000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic logic [63:0] rand_word64();
    return {$urandom, $urandom};
  endfunction

  // Random stall decision shared by both sides; never stall during a calm stretch
  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 8);
  endfunction

  function automatic evt_t mk_event(logic [2:0] kind, logic [63:0] tag, logic [63:0] epoch,
                                    logic [1:0] outcome, logic lost, logic drained);
    evt_t e;
    e.kind        = kind;
    e.tag         = tag;
    e.error_epoch = epoch;
    e.outcome     = outcome;
    e.dev_lost    = lost;
    e.drained     = drained;
    return e;
  endfunction

  // Apply one event to the tracker copy and return the result it must produce
  function automatic res_t track_event(evt_t e);
    res_t r;
    logic live;
    logic refused;
    logic poisoned;
    r        = '0;
    refused  = 1'b0;
    live     = trk_active && (e.tag == trk_tag);
    r.terminal = VERDICT_NONE;
    case (e.kind)
      KIND_BEGIN: begin
        // refused begin is not evidence, so it is not counted
        if (!trk_active && e.tag != '0) begin
          trk_tag      = e.tag;
          trk_baseline = e.error_epoch;
          trk_queue    = Q_PENDING;
          trk_scope    = S_PENDING;
          trk_expired  = 1'b0;
          trk_active   = 1'b1;
          r.accepted   = 1'b1;
        end
      end
      KIND_QUEUE: begin
        if (live && e.outcome != Q_PENDING && trk_queue == Q_PENDING) begin
          trk_queue  = e.outcome;
          r.accepted = 1'b1;
        end else begin
          refused = 1'b1;
        end
      end
      KIND_SCOPE: begin
        if (live && (e.outcome == S_CLEAN || e.outcome == S_ERROR) &&
            trk_scope == S_PENDING) begin
          trk_scope  = e.outcome;
          r.accepted = 1'b1;
        end else begin
          refused = 1'b1;
        end
      end
      KIND_EXPIRE: begin
        if (live && !trk_expired) begin
          trk_expired = 1'b1;
          r.accepted  = 1'b1;
        end else begin
          refused = 1'b1;
        end
      end
      KIND_OBSERVE: begin
        if (live) begin
          poisoned = (trk_queue == Q_ERROR) || (trk_queue == Q_CANCELLED) ||
                     (trk_scope == S_ERROR) || e.dev_lost ||
                     (e.error_epoch != trk_baseline);
          r.accepted = 1'b1;
          if (poisoned) begin
            if (e.drained) r.terminal = VERDICT_FAILURE;
          end else if (trk_queue == Q_SUCCESS && trk_scope == S_CLEAN) begin
            r.terminal = VERDICT_SUCCESS;
          end else if (e.drained) begin
            r.terminal = VERDICT_FAILURE;
          end
          if (r.terminal != VERDICT_NONE) trk_active = 1'b0;
        end else begin
          refused = 1'b1;
        end
      end
      default: ;  // reserved kinds leave everything alone
    endcase
    if (refused && trk_rejects != '1) trk_rejects++;
    r.busy_res     = trk_active;
    r.reject_total = trk_rejects;
    return r;
  endfunction

  // Drive one event, hold it until the transfer, then record what it must yield.
  // Valid stays high across back-to-back events, so it gets one assignment per edge.
  task automatic post_event(evt_t e);
    while (take_break()) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_if.valid       <= 1'b1;
    evt_if.kind        <= e.kind;
    evt_if.tag         <= e.tag;
    evt_if.error_epoch <= e.error_epoch;
    evt_if.outcome     <= e.outcome;
    evt_if.dev_lost    <= e.dev_lost;
    evt_if.drained     <= e.drained;
    @(posedge clk_i);
    while (!evt_if.ready) @(posedge clk_i);
    due_results.push_back(track_event(e));
    items_sent++;
  endtask

  // Result side: check each transfer against the oldest expectation, then stall at random
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        $error("result with no event outstanding: accepted %0d terminal %0d",
               res_if.accepted, res_if.terminal);
        fail_count++;
      end else begin
        want = due_results.pop_front();
        if (res_if.accepted !== want.accepted) begin
          $error("accepted mismatch: expected %0d, got %0d", want.accepted, res_if.accepted);
          fail_count++;
        end
        if (res_if.terminal !== want.terminal) begin
          $error("terminal mismatch: expected %0d, got %0d", want.terminal, res_if.terminal);
          fail_count++;
        end
        if (res_if.busy_res !== want.busy_res) begin
          $error("busy_res mismatch: expected %0d, got %0d", want.busy_res, res_if.busy_res);
          fail_count++;
        end
        if (res_if.reject_total !== want.reject_total) begin
          $error("reject_total mismatch: expected %0d, got %0d",
                 want.reject_total, res_if.reject_total);
          fail_count++;
        end
      end
    end
    res_if.ready <= !take_break();
  end

  // Hand-picked events: field extremes, every kind, and each refusal path
  task automatic test_directed();
    post_event(mk_event(KIND_BEGIN, '0, EPOCH_MAX, Q_PENDING, 1'b0, 1'b0));    // zero tag
    post_event(mk_event(KIND_QUEUE, TAG_MAX, '0, Q_SUCCESS, 1'b0, 1'b0));     // inactive
    post_event(mk_event(KIND_BEGIN, TAG_MAX, EPOCH_MAX, Q_CANCELLED, 1'b1, 1'b1));
    post_event(mk_event(KIND_BEGIN, 64'd5, '0, Q_PENDING, 1'b0, 1'b0));       // already active
    post_event(mk_event(KIND_QUEUE, TAG_MAX, '0, Q_PENDING, 1'b0, 1'b0));     // pending result
    post_event(mk_event(KIND_QUEUE, TAG_MAX - 1, '0, Q_SUCCESS, 1'b0, 1'b0)); // wrong tag
    post_event(mk_event(KIND_QUEUE, TAG_MAX, '0, Q_SUCCESS, 1'b0, 1'b0));
    post_event(mk_event(KIND_QUEUE, TAG_MAX, '0, Q_ERROR, 1'b0, 1'b0));       // repeat
    post_event(mk_event(KIND_SCOPE, TAG_MAX, '0, S_UNDEFINED, 1'b0, 1'b0));
    post_event(mk_event(KIND_SCOPE, TAG_MAX, '0, S_CLEAN, 1'b1, 1'b1));
    post_event(mk_event(KIND_EXPIRE, TAG_MAX, '0, Q_PENDING, 1'b0, 1'b0));
    post_event(mk_event(KIND_EXPIRE, TAG_MAX, '0, Q_PENDING, 1'b0, 1'b0));    // repeat
    post_event(mk_event(KIND_OBSERVE, 64'd1, EPOCH_MAX, Q_PENDING, 1'b0, 1'b1));
    post_event(mk_event(KIND_OBSERVE, TAG_MAX, EPOCH_MAX, Q_PENDING, 1'b0, 1'b0)); // success
    // queue error: no verdict until drained
    post_event(mk_event(KIND_BEGIN, 64'd1, '0, Q_PENDING, 1'b0, 1'b0));
    post_event(mk_event(KIND_QUEUE, 64'd1, '0, Q_ERROR, 1'b0, 1'b0));
    post_event(mk_event(KIND_OBSERVE, 64'd1, '0, Q_PENDING, 1'b0, 1'b0));
    post_event(mk_event(KIND_OBSERVE, 64'd1, '0, Q_PENDING, 1'b0, 1'b1));
    // cancel, scope error, epoch change and device loss
    post_event(mk_event(KIND_BEGIN, 64'd2, '0, Q_PENDING, 1'b0, 1'b0));
    post_event(mk_event(KIND_QUEUE, 64'd2, '0, Q_CANCELLED, 1'b0, 1'b0));
    post_event(mk_event(KIND_SCOPE, 64'd2, '0, S_ERROR, 1'b0, 1'b0));
    post_event(mk_event(KIND_OBSERVE, 64'd2, 64'd1, Q_PENDING, 1'b0, 1'b0));
    post_event(mk_event(KIND_OBSERVE, 64'd2, '0, Q_PENDING, 1'b1, 1'b1));
    // reserved kinds change nothing
    post_event(mk_event(KIND_RSVD5, 64'd3, '0, Q_SUCCESS, 1'b0, 1'b0));
    post_event(mk_event(KIND_RSVD6, '0, EPOCH_MAX, Q_ERROR, 1'b1, 1'b0));
    post_event(mk_event(KIND_RSVD7, TAG_MAX, '0, Q_CANCELLED, 1'b0, 1'b1));
  endtask

  // One submission from begin to retirement, with random evidence in between
  task automatic run_session();
    logic [63:0] tag;
    logic [63:0] base;
    logic [63:0] ev_tag;
    logic [63:0] epoch;
    logic [1:0]  code;
    int          pick;
    int          steps;
    tag = ($urandom_range(3) == 0) ? 64'($urandom_range(1, 15)) : rand_word64();
    if (tag == '0) tag = 64'd1;
    base = ($urandom_range(7) == 0) ? '0 : rand_word64();
    post_event(mk_event(KIND_BEGIN, tag, base, 2'($urandom_range(3)),
                        1'($urandom), 1'($urandom)));
    steps = 0;
    while (trk_active && steps < 12) begin
      // mostly the live tag, sometimes a near miss
      ev_tag = ($urandom_range(9) == 0) ? (tag ^ (64'd1 << $urandom_range(63))) : tag;
      pick   = $urandom_range(99);
      if (pick < 30) begin
        pick = $urandom_range(99);
        code = (pick < 55) ? Q_SUCCESS : (pick < 75) ? Q_ERROR :
               (pick < 90) ? Q_CANCELLED : Q_PENDING;
        post_event(mk_event(KIND_QUEUE, ev_tag, rand_word64(), code,
                            1'($urandom), 1'($urandom)));
      end else if (pick < 60) begin
        pick = $urandom_range(99);
        code = (pick < 70) ? S_CLEAN : (pick < 87) ? S_ERROR :
               (pick < 95) ? S_PENDING : S_UNDEFINED;
        post_event(mk_event(KIND_SCOPE, ev_tag, rand_word64(), code,
                            1'($urandom), 1'($urandom)));
      end else if (pick < 72) begin
        post_event(mk_event(KIND_EXPIRE, ev_tag, rand_word64(), 2'($urandom_range(3)),
                            1'($urandom), 1'($urandom)));
      end else begin
        epoch = ($urandom_range(9) < 8) ? base : rand_word64();
        post_event(mk_event(KIND_OBSERVE, ev_tag, epoch, 2'($urandom_range(3)),
                            ($urandom_range(9) == 0), 1'($urandom)));
      end
      steps++;
    end
    // retire whatever is still open so the next begin is accepted
    if (trk_active) post_event(mk_event(KIND_OBSERVE, tag, base, Q_PENDING, 1'b0, 1'b1));
  endtask

  // Back-to-back sessions with neither side stalling
  task automatic test_calm_sessions();
    calm = 1'b1;
    while (items_sent < 180) run_session();
    calm = 1'b0;
  endtask

  task automatic test_random_sessions();
    while (items_sent < 870) run_session();
  endtask

  // Unstructured events, reserved kinds included, tags often the live one
  task automatic test_noise();
    logic [63:0] tag;
    repeat (80) begin
      case ($urandom_range(2))
        0:       tag = trk_tag;
        1:       tag = '0;
        default: tag = rand_word64();
      endcase
      post_event(mk_event(3'($urandom_range(7)), tag,
                          ($urandom_range(1) == 0) ? trk_baseline : rand_word64(),
                          2'($urandom_range(3)), 1'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    int unsigned guard;
    rst_ni             <= 1'b0;
    evt_if.valid       <= 1'b0;
    evt_if.kind        <= KIND_BEGIN;
    evt_if.tag         <= '0;
    evt_if.error_epoch <= '0;
    evt_if.outcome     <= Q_PENDING;
    evt_if.dev_lost    <= 1'b0;
    evt_if.drained     <= 1'b0;
    trk_active   = 1'b0;
    trk_tag      = '0;
    trk_baseline = '0;
    trk_queue    = Q_PENDING;
    trk_scope    = S_PENDING;
    trk_expired  = 1'b0;
    trk_rejects  = '0;
    fail_count   = 0;
    items_sent   = 0;
    calm         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_calm_sessions();
    test_random_sessions();
    test_noise();
    evt_if.valid <= 1'b0;

    // drain outstanding results, then give the two-stage pipe time to misbehave
    guard = 0;
    while (due_results.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      fail_count++;
    end
    repeat (8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
